// ===== rtl/core/rfft_pkg.sv =====
// ----------------------------------------------------------------------------
// rfft_pkg
// Shared types, constants and twiddle helpers for the radix-2 FFT core.
// ----------------------------------------------------------------------------
package rfft_pkg;

	localparam int SAMPLE_W = 16;
	localparam int BIN_W = 27;
	localparam int IDX_W = 10;
	localparam int CFG_W = 4;
	localparam int DEF_MAX_POINTS = 1024;
	localparam int DEF_TWIDDLE_BITS = 16;
	localparam logic [CFG_W-1:0] CFG_RESET = 4'd10;

	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [BIN_W-1:0] bin_t;
	typedef logic [CFG_W-1:0] log2_t;

	typedef struct packed {
		logic    wr;
		sample_t re;
		sample_t im;
	} ld_req_t;

	typedef enum logic [7:0] {
		E_IDLE = 8'b0000_0001,
		E_CPRD = 8'b0000_0010,
		E_CPWR = 8'b0000_0100,
		E_BRD  = 8'b0000_1000,
		E_BMUL = 8'b0001_0000,
		E_BROT = 8'b0010_0000,
		E_BWA  = 8'b0100_0000,
		E_BWB  = 8'b1000_0000
	} eng_state_t;

	// restoring long division, used only while building tables
	function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Taylor series in Q30, clamped at zero
	function automatic longint unsigned series_q30(longint unsigned x, bit want_sin);
		longint unsigned x2;
		longint unsigned term;
		longint unsigned d;
		longint sum;
		x2 = (x * x) >> 30;
		term = want_sin ? x : ONE_Q30;
		sum = longint'(term);
		for (longint unsigned i = 1; i <= 12; i++) begin
			d = want_sin ? (2 * i) * (2 * i + 1) : (2 * i - 1) * (2 * i);
			term = udiv((term * x2) >> 30, d);
			if (i[0]) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		return (sum < 0) ? 64'd0 : longint'(sum);
	endfunction

	function automatic longint unsigned to_twiddle(longint unsigned v, int tb);
		int sh;
		longint unsigned r;
		longint unsigned mx;
		sh = 30 - (tb - 1);
		r = (v + (64'd1 << (sh - 1))) >> sh;
		mx = (64'd1 << (tb - 1)) - 1;
		return (r > mx) ? mx : r;
	endfunction

endpackage

// ===== rtl/core/rfft_cmdq.sv =====
// ----------------------------------------------------------------------------
// rfft_cmdq
// Two-entry queue of transform commands from the front end to the engine.
// ----------------------------------------------------------------------------
module rfft_cmdq import rfft_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  log2_t push_l,
	input  logic  pop,
	output log2_t pop_l,
	output logic  empty
);

	log2_t      slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign do_push = push && (cnt_q != 2'd2);
	assign do_pop = pop && (cnt_q != 2'd0);
	assign empty = (cnt_q == 2'd0);
	assign pop_l = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wptr_q] <= push_l;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wptr_q <= ~wptr_q;
			if (do_pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

// ===== rtl/core/rfft_front.sv =====
// ----------------------------------------------------------------------------
// rfft_front
// Accepts samples, tracks frame position and size, issues transform commands
// and presents one result per accepted sample.
// ----------------------------------------------------------------------------
module rfft_front import rfft_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	localparam int AW = $clog2(MAX_POINTS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  sample_t       sample_real,
	input  sample_t       sample_imag,
	input  logic          cfg_valid,
	input  log2_t         cfg_data,
	input  logic          eng_done,
	input  bin_t          rd_real,
	input  bin_t          rd_imag,
	output ld_req_t       ld_req,
	output logic [AW-1:0] acc_addr,
	output logic          push,
	output log2_t         push_l,
	output bin_t          bin_real,
	output bin_t          bin_imag,
	output logic [IDX_W-1:0] bin_index,
	output logic          bin_valid,
	output logic          bin_last,
	output logic          bin_strobe
);

	log2_t            cfg_q;
	log2_t            l_eff;
	logic [AW:0]      n_full;
	logic [AW-1:0]    nm1;
	logic [AW-1:0]    pos_q;
	logic             ready_q;
	logic             accept;
	logic             last;
	logic             strobe_q;
	logic             valid_q;
	logic             last_q;
	logic [IDX_W-1:0] idx_q;

	assign accept = start && !busy;

	always_comb begin
		if (cfg_q < log2_t'(1)) l_eff = log2_t'(1);
		else if (cfg_q > log2_t'(AW)) l_eff = log2_t'(AW);
		else l_eff = cfg_q;
	end

	assign n_full = (AW+1)'(1) << l_eff;
	assign nm1 = n_full[AW-1:0] - AW'(1);
	assign last = (pos_q >= nm1);

	assign ld_req = '{wr: accept, re: sample_real, im: sample_imag};
	assign acc_addr = pos_q;
	assign push = accept && last;
	assign push_l = l_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
			pos_q <= '0;
			ready_q <= 1'b0;
			strobe_q <= 1'b0;
			valid_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			if (cfg_valid) cfg_q <= cfg_data;
			if (eng_done) ready_q <= 1'b1;
			strobe_q <= accept;
			if (accept) begin
				valid_q <= ready_q;
				last_q <= last;
				pos_q <= last ? '0 : pos_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) idx_q <= IDX_W'(pos_q);
	end

	assign bin_real = valid_q ? rd_real : '0;
	assign bin_imag = valid_q ? rd_imag : '0;
	assign bin_index = idx_q;
	assign bin_valid = valid_q;
	assign bin_last = last_q;
	assign bin_strobe = strobe_q;

endmodule

// ===== rtl/core/rfft_engine.sv =====
// ----------------------------------------------------------------------------
// rfft_engine
// Frame and spectrum memories, bit-reversed copy and a shared radix-2
// butterfly sequenced over all stages.
// ----------------------------------------------------------------------------
module rfft_engine import rfft_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	parameter int TWIDDLE_BITS = DEF_TWIDDLE_BITS,
	localparam int AW = $clog2(MAX_POINTS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ld_req_t       ld_req,
	input  logic [AW-1:0] acc_addr,
	input  logic          cmd_empty,
	input  log2_t         cmd_l,
	output logic          cmd_pop,
	output logic          active,
	output logic          done,
	output bin_t          rd_real,
	output bin_t          rd_imag
);

	localparam int DW = AW + SAMPLE_W + 2;
	localparam int TB = TWIDDLE_BITS;
	localparam int TWA = (AW > 1) ? AW - 1 : 1;
	localparam int TW_DEPTH = 1 << TWA;
	localparam int PW = DW + TB;
	localparam int SW = (DW > BIN_W) ? DW : BIN_W;
	localparam int HALF_PTS = MAX_POINTS / 2;
	localparam int QUARTER_PTS = MAX_POINTS / 4;
	localparam logic signed [SW-1:0] SAT_HI = SW'((64'd1 << (BIN_W - 1)) - 1);
	localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

	typedef logic [2*TB-1:0] tw_rom_t [TW_DEPTH];
	typedef logic signed [DW-1:0] data_t;

	function automatic tw_rom_t build_tw();
		tw_rom_t rom;
		longint unsigned x;
		longint unsigned cv;
		longint unsigned sv;
		for (int k = 0; k < TW_DEPTH; k++) begin
			rom[k] = '0;
			if (k < HALF_PTS) begin
				if (4 * k <= MAX_POINTS) begin
					x = udiv(PI_Q30 * 2 * longint'(k), MAX_POINTS);
					cv = to_twiddle(series_q30(x, 1'b0), TB);
					sv = to_twiddle(series_q30(x, 1'b1), TB);
					rom[k] = {TB'(cv), TB'(sv)};
				end else begin
					x = udiv(PI_Q30 * 2 * longint'(k - QUARTER_PTS), MAX_POINTS);
					cv = to_twiddle(series_q30(x, 1'b1), TB);
					sv = to_twiddle(series_q30(x, 1'b0), TB);
					rom[k] = {TB'(-cv), TB'(sv)};
				end
			end
		end
		return rom;
	endfunction

	localparam tw_rom_t TW_ROM = build_tw();

	function automatic bin_t sat_bin(data_t v);
		logic signed [SW-1:0] e;
		e = SW'(v);
		if (e > SAT_HI) return BIN_W'(SAT_HI);
		if (e < SAT_LO) return BIN_W'(SAT_LO);
		return BIN_W'(e);
	endfunction

	logic [2*SAMPLE_W-1:0] load_mem [MAX_POINTS];
	logic [2*DW-1:0]       spec_mem [MAX_POINTS];

	eng_state_t       state_q;
	log2_t            l_q;
	log2_t            s_q;
	logic [AW-1:0]    i_q;
	logic [2*SAMPLE_W-1:0] ld_rd_q;
	logic [2*DW-1:0]  rd_a_q;
	logic [2*DW-1:0]  rd_b_q;
	logic [2*TB-1:0]  tw_q;

	logic signed [PW-1:0] p_rc_q, p_is_q, p_ic_q, p_rs_q;
	data_t            ur_q, ui_q, vr_q, vi_q;
	logic signed [PW:0] sum_r, sum_i;

	logic [AW:0]      n_full;
	logic [AW-1:0]    nm1;
	logic [AW:0]      half_full;
	logic [AW-1:0]    hmask;
	logic [AW-1:0]    k_idx;
	logic [AW-1:0]    addr_a;
	logic [AW-1:0]    addr_b;
	logic [AW-1:0]    bf_a;
	logic [AW-1:0]    bf_b;
	logic [AW-1:0]    rev_full;
	logic [AW-1:0]    rev;
	logic [TWA-1:0]   tw_idx;
	logic             sp_we;
	logic [AW-1:0]    sp_waddr;
	logic [2*DW-1:0]  sp_wdata;
	logic             bf_last;
	data_t            br, bi, ar, ai;
	logic signed [TB-1:0] tc, ts;

	assign n_full = (AW+1)'(1) << l_q;
	assign nm1 = n_full[AW-1:0] - AW'(1);
	assign half_full = (AW+1)'(1) << (s_q - log2_t'(1));
	assign hmask = half_full[AW-1:0] - AW'(1);
	assign k_idx = i_q & hmask;
	assign bf_a = ((i_q >> (s_q - log2_t'(1))) << s_q) | k_idx;
	assign bf_b = bf_a | half_full[AW-1:0];
	assign tw_idx = TWA'(k_idx << (log2_t'(AW) - s_q));
	assign bf_last = (i_q == (nm1 >> 1));

	always_comb begin
		for (int b = 0; b < AW; b++) rev_full[AW-1-b] = i_q[b];
	end
	assign rev = rev_full >> (log2_t'(AW) - l_q);

	assign active = (state_q != E_IDLE);
	assign cmd_pop = (state_q == E_IDLE) && !cmd_empty;
	assign done = (state_q == E_BWB) && bf_last && (s_q == l_q);
	assign addr_a = active ? bf_a : acc_addr;
	assign addr_b = bf_b;

	assign br = data_t'($signed(rd_b_q[2*DW-1:DW]));
	assign bi = data_t'($signed(rd_b_q[DW-1:0]));
	assign ar = data_t'($signed(rd_a_q[2*DW-1:DW]));
	assign ai = data_t'($signed(rd_a_q[DW-1:0]));
	assign tc = $signed(tw_q[2*TB-1:TB]);
	assign ts = $signed(tw_q[TB-1:0]);

	assign sum_r = (PW+1)'(p_rc_q) + (PW+1)'(p_is_q) + (PW+1)'(1 << (TB - 2));
	assign sum_i = (PW+1)'(p_ic_q) - (PW+1)'(p_rs_q) + (PW+1)'(1 << (TB - 2));

	always_comb begin
		sp_we = 1'b0;
		sp_waddr = bf_a;
		sp_wdata = {DW'(ur_q + vr_q), DW'(ui_q + vi_q)};
		case (state_q)
			E_CPWR: begin
				sp_we = 1'b1;
				sp_waddr = rev;
				sp_wdata = {DW'($signed(ld_rd_q[2*SAMPLE_W-1:SAMPLE_W])),
				            DW'($signed(ld_rd_q[SAMPLE_W-1:0]))};
			end
			E_BWA: begin
				sp_we = 1'b1;
			end
			E_BWB: begin
				sp_we = 1'b1;
				sp_waddr = bf_b;
				sp_wdata = {DW'(ur_q - vr_q), DW'(ui_q - vi_q)};
			end
			default: sp_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld_req.wr) load_mem[acc_addr] <= {ld_req.re, ld_req.im};
		ld_rd_q <= load_mem[i_q];
	end

	always_ff @(posedge clk) begin
		if (sp_we) spec_mem[sp_waddr] <= sp_wdata;
		rd_a_q <= spec_mem[addr_a];
		rd_b_q <= spec_mem[addr_b];
		tw_q <= TW_ROM[tw_idx];
	end

	always_ff @(posedge clk) begin
		if (state_q == E_BMUL) begin
			p_rc_q <= PW'(br * tc);
			p_is_q <= PW'(bi * ts);
			p_ic_q <= PW'(bi * tc);
			p_rs_q <= PW'(br * ts);
			ur_q <= ar;
			ui_q <= ai;
		end
		if (state_q == E_BROT) begin
			vr_q <= DW'(sum_r >>> (TB - 1));
			vi_q <= DW'(sum_i >>> (TB - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			l_q <= log2_t'(1);
			s_q <= log2_t'(1);
			i_q <= '0;
		end else begin
			case (state_q)
				E_IDLE: begin
					if (!cmd_empty) begin
						l_q <= cmd_l;
						i_q <= '0;
						state_q <= E_CPRD;
					end
				end
				E_CPRD: state_q <= E_CPWR;
				E_CPWR: begin
					if (i_q == nm1) begin
						i_q <= '0;
						s_q <= log2_t'(1);
						state_q <= E_BRD;
					end else begin
						i_q <= i_q + AW'(1);
						state_q <= E_CPRD;
					end
				end
				E_BRD: state_q <= E_BMUL;
				E_BMUL: state_q <= E_BROT;
				E_BROT: state_q <= E_BWA;
				E_BWA: state_q <= E_BWB;
				E_BWB: begin
					if (bf_last) begin
						i_q <= '0;
						if (s_q == l_q) begin
							state_q <= E_IDLE;
						end else begin
							s_q <= s_q + log2_t'(1);
							state_q <= E_BRD;
						end
					end else begin
						i_q <= i_q + AW'(1);
						state_q <= E_BRD;
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	assign rd_real = sat_bin(data_t'($signed(rd_a_q[2*DW-1:DW])));
	assign rd_imag = sat_bin(data_t'($signed(rd_a_q[DW-1:0])));

endmodule

// ===== rtl/core/radix2_complex_fft_core.sv =====
// A bin appears, strobed, in the cycle after its sample transfer.
// Throughput: one sample per cycle within a frame; after the last sample of a
// frame busy stays high, and no new sample is taken, until the bit-reversed copy and
// all stages are done, set by the single shared butterfly and its memory port.
// Reset clears position, size (1024 points) and the ready flag; memories are
// not cleared. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// radix2_complex_fft_core
// Streaming radix-2 decimation-in-time FFT with frame-pipelined output.
// ----------------------------------------------------------------------------
module radix2_complex_fft_core import rfft_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	parameter int TWIDDLE_BITS = DEF_TWIDDLE_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  sample_t          sample_real,
	input  sample_t          sample_imag,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  log2_t            cfg_data,
	output bin_t             bin_real,
	output bin_t             bin_imag,
	output logic [IDX_W-1:0] bin_index,
	output logic             bin_valid,
	output logic             bin_last,
	output logic             bin_strobe
);

	localparam int AW = $clog2(MAX_POINTS);

	ld_req_t       ld_req;
	logic [AW-1:0] acc_addr;
	logic          push;
	log2_t         push_l;
	logic          pop;
	log2_t         pop_l;
	logic          q_empty;
	logic          eng_active;
	logic          eng_done;
	bin_t          rd_real;
	bin_t          rd_imag;

	assign busy = !q_empty || eng_active;
	assign cfg_ready = 1'b1;

	rfft_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sample_real(sample_real), .sample_imag(sample_imag),
		.cfg_valid(cfg_valid), .cfg_data(cfg_data), .eng_done(eng_done),
		.rd_real(rd_real), .rd_imag(rd_imag), .ld_req(ld_req), .acc_addr(acc_addr),
		.push(push), .push_l(push_l), .bin_real(bin_real), .bin_imag(bin_imag),
		.bin_index(bin_index), .bin_valid(bin_valid), .bin_last(bin_last),
		.bin_strobe(bin_strobe)
	);

	rfft_cmdq u_cmdq (
		.clk(clk), .arst_n(arst_n), .push(push), .push_l(push_l),
		.pop(pop), .pop_l(pop_l), .empty(q_empty)
	);

	rfft_engine #(.MAX_POINTS(MAX_POINTS), .TWIDDLE_BITS(TWIDDLE_BITS)) u_engine (
		.clk(clk), .arst_n(arst_n), .ld_req(ld_req), .acc_addr(acc_addr),
		.cmd_empty(q_empty), .cmd_l(pop_l), .cmd_pop(pop), .active(eng_active),
		.done(eng_done), .rd_real(rd_real), .rd_imag(rd_imag)
	);

endmodule
